/* src/adw_pkg.sv */
// Shared types and constants for the audio distortion waveshaper.
`default_nettype none
package adw_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam int PRE_GAIN_W   = 24;
  localparam int BLEND_W      = 17;
  localparam int INV_BLEND_W  = 23;
  localparam int VOLUME_W     = 18;

  localparam logic [CFG_INDEX_W-1:0] CFG_PRE_GAIN   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLEND      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INV_BLEND  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHAPE_MODE = 3'd4;

  localparam logic [PRE_GAIN_W-1:0]  PRE_GAIN_RST  = 24'd3072000;
  localparam logic [BLEND_W-1:0]     BLEND_RST     = 17'd32768;
  localparam logic [INV_BLEND_W-1:0] INV_BLEND_RST = 23'd131072;
  localparam logic [VOLUME_W-1:0]    VOLUME_RST    = 18'd98304;

  localparam logic [63:0] INV_E_Q30    = 64'd395007542;
  localparam int          SERIES_TERMS = 20;

  typedef enum logic [1:0] {
    SHAPE_SOFT = 2'd0,
    SHAPE_HARD = 2'd1,
    SHAPE_HALF = 2'd2,
    SHAPE_FULL = 2'd3
  } shape_t;

  typedef enum logic [2:0] {
    KIND_MIX17 = 3'd0,
    KIND_MIX18 = 3'd1,
    KIND_PASS  = 3'd2,
    KIND_NEG   = 3'd3,
    KIND_ZERO  = 3'd4
  } kind_t;

endpackage
`default_nettype wire

/* src/audio_distortion_waveshaper_unit.sv */
// Top level of the waveshaping distortion pipeline.
//
//   channel   signals                                         direction
//   sample    sample_valid, sample_ready, sample_in           in
//   result    result_valid, result_ready, sample_out, clipped out
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data       in
//
// One sample per cycle while result_ready is high; nine register stages from
// accept to result_valid. Stage depth is set by the two input multiplies, the two
// split partial-product multiplies and the wide adds.
// The exp table is a constant array read into a register in stage three.
// Reset clears all stage valid bits and loads default settings.
// A stage holds while the next one is full and stalled; bubbles still fill.
`default_nettype none
module audio_distortion_waveshaper_unit
  import adw_pkg::*;
#(
  parameter int SAMPLE_WIDTH    = 24,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           sample_valid,
  output logic                          sample_ready,
  input  wire  signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic                          result_valid,
  input  wire                           result_ready,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out,
  output logic                          clipped,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [CFG_INDEX_W-1:0]        cfg_index,
  input  wire  [CFG_DATA_W-1:0]         cfg_data
);

  localparam int W   = SAMPLE_WIDTH;
  localparam int F   = W - 1;
  localparam int DW  = W + 13;
  localparam int CW  = W + 8;
  localparam int MW  = DW;
  localparam int L   = 24;
  localparam int IW  = $clog2(EXP_TABLE_DEPTH);
  localparam int SHW = MW + 2;
  localparam int XW  = MW + 3;
  localparam int PW  = XW + 19;
  localparam int YW  = PW - 17;
  localparam int NS  = 9;

  localparam logic signed [DW-1:0]  ONE_D   = {{(DW-W){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [DW-1:0]  NONE_D  = -ONE_D;
  localparam logic signed [SHW-1:0] ONE_S   = {{(SHW-W){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [YW:0]    MAX_Y   = {{(YW-F+1){1'b0}}, {F{1'b1}}};
  localparam logic signed [YW:0]    MIN_Y   = {{(YW-F+1){1'b1}}, {F{1'b0}}};
  localparam logic [IW:0]           DEPTH_V = (IW+1)'(EXP_TABLE_DEPTH);

  function automatic logic [W-1:0] exp_entry(input int k);
    logic [63:0]        xq;
    logic [63:0]        ip;
    logic [63:0]        f;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic [63:0]        v;
    xq  = (64'(k) << 33) / EXP_TABLE_DEPTH;
    ip  = xq >> 30;
    f   = xq & ((64'd1 << 30) - 64'd1);
    t   = 64'd1 << 30;
    sum = 64'sd1 <<< 30;
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      t = ((t * f) >> 30) / 64'(n);
      if (n % 2 == 1) begin
        sum = sum - $signed(t);
      end else begin
        sum = sum + $signed(t);
      end
    end
    v = $unsigned(sum);
    for (int j = 0; j < 8; j++) begin
      if (64'(j) < ip) begin
        v = (v * INV_E_Q30) >> 30;
      end
    end
    if (F < 30) begin
      v = (v + (64'd1 << ((29 - F) & 63))) >> ((30 - F) & 63);
    end else begin
      v = v << ((F - 30) & 63);
    end
    return v[W-1:0];
  endfunction

  logic [W-1:0] exp_rom [EXP_TABLE_DEPTH];

  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
    assign exp_rom[g] = exp_entry(g);
  end

  // configuration registers
  logic [PRE_GAIN_W-1:0]  pre_gain;
  logic [BLEND_W-1:0]     blend_gain;
  logic [INV_BLEND_W-1:0] inv_blend_gain;
  logic [VOLUME_W-1:0]    volume_gain;
  shape_t                 shape_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_gain       <= PRE_GAIN_RST;
      blend_gain     <= BLEND_RST;
      inv_blend_gain <= INV_BLEND_RST;
      volume_gain    <= VOLUME_RST;
      shape_mode     <= SHAPE_SOFT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PRE_GAIN:   pre_gain       <= cfg_data[PRE_GAIN_W-1:0];
        CFG_BLEND:      blend_gain     <= cfg_data[BLEND_W-1:0];
        CFG_INV_BLEND:  inv_blend_gain <= cfg_data[INV_BLEND_W-1:0];
        CFG_VOLUME:     volume_gain    <= cfg_data[VOLUME_W-1:0];
        CFG_SHAPE_MODE: shape_mode     <= shape_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // stage valids and advance chain
  logic [NS:1] v;
  logic [NS:1] en;

  always_comb begin
    en[NS] = !v[NS] || result_ready;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign sample_ready = en[1];
  assign result_valid = v[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= sample_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 1: drive and clean products
  logic signed [W+24:0] prod_d;
  logic signed [W+23:0] prod_c;
  logic signed [DW-1:0] d1;
  logic signed [CW-1:0] c1;

  assign prod_d = sample_in * $signed({1'b0, pre_gain});
  assign prod_c = sample_in * $signed({1'b0, inv_blend_gain});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1 <= prod_d[W+24:12];
      c1 <= prod_c[W+23:16];
    end
  end

  // stage 2: magnitude and routing
  logic [MW-1:0]        mag_next;
  kind_t                kind_next;
  logic [MW-1:0]        mag2;
  kind_t                kind2;
  logic                 dpos2;
  logic signed [W:0]    pd2;
  logic signed [CW-1:0] c2;
  logic                 dpos_next;

  assign mag_next  = d1[DW-1] ? MW'(-d1) : MW'(d1);
  assign dpos_next = !d1[DW-1] && (d1 != '0);

  always_comb begin
    kind_next = KIND_MIX17;
    case (shape_mode) inside
      SHAPE_SOFT: kind_next = KIND_MIX17;
      SHAPE_HARD: begin
        if (d1 > ONE_D) begin
          kind_next = KIND_MIX17;
        end else if (d1 < NONE_D) begin
          kind_next = KIND_NEG;
        end else begin
          kind_next = KIND_PASS;
        end
      end
      SHAPE_HALF: kind_next = dpos_next ? KIND_MIX18 : KIND_ZERO;
      SHAPE_FULL: kind_next = KIND_MIX18;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mag2  <= mag_next;
      kind2 <= kind_next;
      dpos2 <= dpos_next;
      pd2   <= d1[W:0];
      c2    <= c1;
    end
  end

  // stage 3: table read and rectifier partial products
  logic [F+3+IW:0]       idx_prod;
  logic [IW-1:0]         idx;
  logic [W-1:0]          e3;
  logic                  eovf3;
  logic [L+BLEND_W-1:0]  rp_lo3;
  logic [MW-L+BLEND_W-1:0] rp_hi3;
  kind_t                 kind3;
  logic                  dpos3;
  logic signed [W:0]     pd3;
  logic signed [CW-1:0]  c3;

  assign idx_prod = mag2[F+2:0] * DEPTH_V;
  assign idx      = idx_prod[F+3 +: IW];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      e3     <= exp_rom[idx];
      eovf3  <= |mag2[MW-1:F+3];
      rp_lo3 <= mag2[L-1:0] * blend_gain;
      rp_hi3 <= mag2[MW-1:L] * blend_gain;
      kind3  <= kind2;
      dpos3  <= dpos2;
      pd3    <= pd2;
      c3     <= c2;
    end
  end

  // stage 4: shaped value
  logic [MW+BLEND_W-1:0]  rsum;
  logic [BLEND_W+F-1:0]   bl_wide;
  logic signed [SHW-1:0]  ev;
  logic signed [SHW-1:0]  shaped_next;
  logic signed [SHW-1:0]  shaped4;
  kind_t                  kind4;
  logic signed [W:0]      pd4;
  logic signed [CW-1:0]   c4;

  assign rsum    = {rp_hi3, {L{1'b0}}} + (MW+BLEND_W)'(rp_lo3);
  assign bl_wide = {blend_gain, {F{1'b0}}};
  assign ev      = eovf3 ? '0 : $signed(SHW'(e3));

  always_comb begin
    shaped_next = '0;
    case (shape_mode) inside
      SHAPE_SOFT: shaped_next = dpos3 ? (ONE_S - ev) : (ev - ONE_S);
      SHAPE_HARD: shaped_next = $signed(SHW'(bl_wide[BLEND_W+F-1:16]));
      SHAPE_HALF, SHAPE_FULL: shaped_next = $signed(SHW'(rsum[MW+BLEND_W-1:16]));
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      shaped4 <= shaped_next;
      kind4   <= kind3;
      pd4     <= pd3;
      c4      <= c3;
    end
  end

  // stage 5: mix with clean
  logic signed [XW-1:0] mix5;
  kind_t                kind5;
  logic signed [W:0]    pd5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      mix5  <= XW'(shaped4) + XW'(c4);
      kind5 <= kind4;
      pd5   <= pd4;
    end
  end

  // stage 6: volume partial products
  logic [L+VOLUME_W-1:0]           vp_lo6;
  logic signed [XW-L+VOLUME_W:0]   vp_hi6;
  kind_t                           kind6;
  logic signed [W:0]               pd6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      vp_lo6 <= mix5[L-1:0] * volume_gain;
      vp_hi6 <= $signed(mix5[XW-1:L]) * $signed({1'b0, volume_gain});
      kind6  <= kind5;
      pd6    <= pd5;
    end
  end

  // stage 7: combine and scale down
  logic signed [PW-1:0] vsum;
  logic signed [PW-1:0] vsh;
  logic signed [YW-1:0] yr7;
  kind_t                kind7;
  logic signed [W:0]    pd7;

  assign vsum = $signed({vp_hi6, {L{1'b0}}}) + $signed({{(PW-L-VOLUME_W){1'b0}}, vp_lo6});
  assign vsh  = (kind6 == KIND_MIX18) ? (vsum >>> 18) : (vsum >>> 17);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      yr7   <= vsh[YW-1:0];
      kind7 <= kind6;
      pd7   <= pd6;
    end
  end

  // stage 8: final select
  logic signed [YW:0] y_next;
  logic signed [YW:0] y8;
  kind_t              kind8;

  always_comb begin
    case (kind7) inside
      KIND_MIX17, KIND_MIX18: y_next = (YW+1)'(yr7);
      KIND_NEG:               y_next = -((YW+1)'(yr7));
      KIND_PASS:              y_next = (YW+1)'(pd7);
      KIND_ZERO:              y_next = '0;
      default:                y_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      y8    <= y_next;
      kind8 <= kind7;
    end
  end

  // stage 9: saturate
  always_ff @(posedge clk) begin
    if (en[9]) begin
      if (y8 > MAX_Y) begin
        sample_out <= MAX_Y[W-1:0];
        clipped    <= 1'b1;
      end else if (y8 < MIN_Y) begin
        sample_out <= MIN_Y[W-1:0];
        clipped    <= 1'b1;
      end else begin
        sample_out <= y8[W-1:0];
        clipped    <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    result_valid && clipped |->
      (sample_out == MAX_Y[W-1:0]) || (sample_out == MIN_Y[W-1:0]))
    else $error("clipped beat not at a rail");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> sample_ready)
    else $error("input stalled with empty output stage");

  a_zero_kind: assert property (@(posedge clk) disable iff (rst)
    v[8] && en[9] && (kind8 == KIND_ZERO) |=> (sample_out == '0) && !clipped)
    else $error("half-wave negative beat not zero");
`endif

endmodule
`default_nettype wire
